// ===== sv/mcst_pkg.sv =====
`default_nettype none

package mcst_pkg;

  // Command codes carried by one input word
  localparam logic [1:0] CMD_FRAME = 2'd0;
  localparam logic [1:0] CMD_TICK  = 2'd1;
  localparam logic [1:0] CMD_QUERY = 2'd2;
  localparam logic [1:0] CMD_BUSERR = 2'd3;

  // Result status codes
  localparam logic [2:0] ST_DONE       = 3'd0;
  localparam logic [2:0] ST_IGNORED    = 3'd1;
  localparam logic [2:0] ST_UNK_PACKET = 3'd2;
  localparam logic [2:0] ST_UNK_SENDER = 3'd3;
  localparam logic [2:0] ST_SHORT      = 3'd4;

  // Configuration register indexes
  localparam logic [1:0] REG_WHEEL_IDS = 2'd0;
  localparam logic [1:0] REG_TIMEOUT   = 2'd1;
  localparam logic [1:0] REG_STATUS    = 2'd2;
  localparam logic [1:0] REG_STATUS5   = 2'd3;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned PTYPE_W    = 21;
  localparam int unsigned SENDER_W   = 8;
  localparam int unsigned ID_SLOTS   = 4;

  // Reset values of the configuration registers
  localparam logic [31:0]        TIMEOUT_RST = 32'd100;
  localparam logic [PTYPE_W-1:0] STATUS_RST  = 21'd9;
  localparam logic [PTYPE_W-1:0] STATUS5_RST = 21'd27;

  // Minimum data lengths of the two status frames
  localparam logic [3:0] MIN_LEN_STATUS  = 4'd4;
  localparam logic [3:0] MIN_LEN_STATUS5 = 4'd6;

  typedef struct packed {
    logic [1:0]  command;
    logic        is_extended;
    logic        is_remote;
    logic [28:0] frame_id;
    logic [3:0]  byte_count;
    logic [31:0] payload_word;
    logic [1:0]  wheel_select;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         status;
    logic               online;
    logic signed [31:0] speed_erpm;
    logic signed [63:0] tachometer_count;
    logic [31:0]        rx_error_count;
    logic [31:0]        unknown_packet_count;
    logic [31:0]        unknown_sender_count;
  } out_item_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;
    logic execute;
  } ctrl_cmd_t;

endpackage

`default_nettype wire

// ===== sv/mcst_stream_if.sv =====
`default_nettype none

interface mcst_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== sv/mcst_ctrl.sv =====
`default_nettype none

module mcst_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output mcst_pkg::ctrl_cmd_t    cmd_o
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic capture, execute;

  // Take a word only when idle; commit once the result register is free
  assign in_ready_o = (state_q == S_IDLE);
  assign capture    = in_valid_i && in_ready_o;
  assign execute    = (state_q == S_EXEC) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (capture) state_d = S_EXEC;
      S_EXEC: if (execute) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Hold the result until taken, load it on commit
  always_comb begin
    out_valid_d = out_valid_q;
    if (execute) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign cmd_o.capture = capture;
  assign cmd_o.execute = execute;

  a_exec_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    execute |=> out_valid_q && (state_q == S_IDLE))
    else $error("commit did not present a result");

  a_stall_holds_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXEC) && out_valid_q && !out_ready_i |=> (state_q == S_EXEC))
    else $error("item left execution while result register was blocked");

endmodule

`default_nettype wire

// ===== sv/mcst_dp.sv =====
`default_nettype none

module mcst_dp #(
  parameter int WHEELS = 4
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire mcst_pkg::ctrl_cmd_t                 cmd_i,
  input  wire mcst_pkg::in_item_t                  item_i,
  output mcst_pkg::out_item_t                      result_o,
  input  wire logic                                cfg_we_i,
  input  wire logic [mcst_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire logic [mcst_pkg::CFG_DATA_W-1:0]     cfg_wdata_i
);

  localparam int WIDX  = (WHEELS > 1) ? $clog2(WHEELS) : 1;
  localparam int SLOTS = (WHEELS < mcst_pkg::ID_SLOTS) ? WHEELS : mcst_pkg::ID_SLOTS;

  // Configuration registers
  logic [31:0]                    wheel_ids_q;
  logic [31:0]                    timeout_q;
  logic [mcst_pkg::PTYPE_W-1:0]   status_type_q;
  logic [mcst_pkg::PTYPE_W-1:0]   status5_type_q;

  // Captured word and per-wheel records
  mcst_pkg::in_item_t item_q;
  logic [31:0] speed_q    [WHEELS];
  logic [31:0] raw_tach_q [WHEELS];
  logic [63:0] tach_ext_q [WHEELS];
  logic [31:0] spd_time_q [WHEELS];
  logic [31:0] tach_time_q[WHEELS];
  logic [WHEELS-1:0] spd_vld_q, spd_vld_d;
  logic [WHEELS-1:0] tach_vld_q, tach_vld_d;
  logic [31:0] now_q, now_d;
  logic [31:0] rx_cnt_q, rx_cnt_d;
  logic [31:0] pkt_cnt_q, pkt_cnt_d;
  logic [31:0] snd_cnt_q, snd_cnt_d;

  // Result register
  logic [2:0]  res_status_q, res_status_d;
  logic        res_online_q, res_online_d;
  logic [31:0] res_speed_q, res_speed_d;
  logic [63:0] res_tach_q, res_tach_d;

  // Decode
  logic [mcst_pkg::PTYPE_W-1:0]  ptype;
  logic [mcst_pkg::SENDER_W-1:0] sender;
  logic                          is_data, hit_spd, hit_tach, found;
  logic [WIDX-1:0]               match_w, rd_idx;
  logic                          q_in_range, online;
  logic [31:0]                   rd_speed, rd_raw, rd_stime, rd_ttime;
  logic [63:0]                   rd_ext, tach_new;
  logic                          rd_svld, rd_tvld;
  logic [31:0]                   tach_delta;
  logic                          wr_speed, wr_tach;

  assign ptype    = item_q.frame_id[28:8];
  assign sender   = item_q.frame_id[7:0];
  assign is_data  = item_q.is_extended && !item_q.is_remote;
  assign hit_spd  = (ptype == status_type_q);
  assign hit_tach = (ptype == status5_type_q);

  // Look up the sender in the ID table, lowest wheel wins
  always_comb begin
    found   = 1'b0;
    match_w = '0;
    for (int w = SLOTS - 1; w >= 0; w--) begin
      if (wheel_ids_q[w*8 +: 8] == sender) begin
        found   = 1'b1;
        match_w = WIDX'(w);
      end
    end
  end

  // One shared read port per record: query wheel or matched sender
  assign q_in_range = (32'(item_q.wheel_select) < 32'(WHEELS));
  assign rd_idx     = (item_q.command == mcst_pkg::CMD_QUERY) ?
                      WIDX'(item_q.wheel_select) : match_w;
  assign rd_speed   = speed_q[rd_idx];
  assign rd_raw     = raw_tach_q[rd_idx];
  assign rd_ext     = tach_ext_q[rd_idx];
  assign rd_stime   = spd_time_q[rd_idx];
  assign rd_ttime   = tach_time_q[rd_idx];
  assign rd_svld    = spd_vld_q[rd_idx];
  assign rd_tvld    = tach_vld_q[rd_idx];

  assign online = rd_svld && rd_tvld &&
                  ((now_q - rd_stime) <= timeout_q) &&
                  ((now_q - rd_ttime) <= timeout_q);

  // Extend the raw tachometer by its signed wrap delta
  assign tach_delta = item_q.payload_word - rd_raw;
  assign tach_new   = rd_tvld ? (rd_ext + {{32{tach_delta[31]}}, tach_delta})
                              : {{32{item_q.payload_word[31]}}, item_q.payload_word};

  always_comb begin
    res_status_d = mcst_pkg::ST_DONE;
    res_online_d = 1'b0;
    res_speed_d  = '0;
    res_tach_d   = '0;
    now_d        = now_q;
    rx_cnt_d     = rx_cnt_q;
    pkt_cnt_d    = pkt_cnt_q;
    snd_cnt_d    = snd_cnt_q;
    wr_speed     = 1'b0;
    wr_tach      = 1'b0;
    case (item_q.command)
      mcst_pkg::CMD_FRAME: begin
        if (!is_data) begin
          res_status_d = mcst_pkg::ST_IGNORED;
        end else if (!hit_spd && !hit_tach) begin
          res_status_d = mcst_pkg::ST_UNK_PACKET;
          pkt_cnt_d    = pkt_cnt_q + 32'd1;
        end else if (!found) begin
          res_status_d = mcst_pkg::ST_UNK_SENDER;
          snd_cnt_d    = snd_cnt_q + 32'd1;
        end else if (hit_spd) begin
          if (item_q.byte_count < mcst_pkg::MIN_LEN_STATUS) begin
            res_status_d = mcst_pkg::ST_SHORT;
            rx_cnt_d     = rx_cnt_q + 32'd1;
          end else begin
            wr_speed = 1'b1;
          end
        end else begin
          if (item_q.byte_count < mcst_pkg::MIN_LEN_STATUS5) begin
            res_status_d = mcst_pkg::ST_SHORT;
            rx_cnt_d     = rx_cnt_q + 32'd1;
          end else begin
            wr_tach = 1'b1;
          end
        end
      end
      mcst_pkg::CMD_TICK: begin
        now_d = now_q + 32'd1;
      end
      mcst_pkg::CMD_QUERY: begin
        if (q_in_range) begin
          res_online_d = online;
          res_speed_d  = online ? rd_speed : '0;
          res_tach_d   = rd_tvld ? rd_ext : '0;
        end
      end
      default: begin
        rx_cnt_d = rx_cnt_q + 32'd1;
      end
    endcase
  end

  // Valid flags of the records
  always_comb begin
    spd_vld_d  = spd_vld_q;
    tach_vld_d = tach_vld_q;
    if (wr_speed) spd_vld_d[match_w]  = 1'b1;
    if (wr_tach)  tach_vld_d[match_w] = 1'b1;
  end

  // Capture the accepted word
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      item_q <= item_i;
    end
  end

  // Update records and the result register on commit
  always_ff @(posedge clk_i) begin
    if (cmd_i.execute) begin
      res_status_q <= res_status_d;
      res_online_q <= res_online_d;
      res_speed_q  <= res_speed_d;
      res_tach_q   <= res_tach_d;
      if (wr_speed) begin
        speed_q[match_w]    <= item_q.payload_word;
        spd_time_q[match_w] <= now_q;
      end
      if (wr_tach) begin
        raw_tach_q[match_w]  <= item_q.payload_word;
        tach_ext_q[match_w]  <= tach_new;
        tach_time_q[match_w] <= now_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spd_vld_q  <= '0;
      tach_vld_q <= '0;
      now_q      <= '0;
      rx_cnt_q   <= '0;
      pkt_cnt_q  <= '0;
      snd_cnt_q  <= '0;
    end else if (cmd_i.execute) begin
      spd_vld_q  <= spd_vld_d;
      tach_vld_q <= tach_vld_d;
      now_q      <= now_d;
      rx_cnt_q   <= rx_cnt_d;
      pkt_cnt_q  <= pkt_cnt_d;
      snd_cnt_q  <= snd_cnt_d;
    end
  end

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wheel_ids_q    <= '0;
      timeout_q      <= mcst_pkg::TIMEOUT_RST;
      status_type_q  <= mcst_pkg::STATUS_RST;
      status5_type_q <= mcst_pkg::STATUS5_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        mcst_pkg::REG_WHEEL_IDS: wheel_ids_q    <= cfg_wdata_i;
        mcst_pkg::REG_TIMEOUT:   timeout_q      <= cfg_wdata_i;
        mcst_pkg::REG_STATUS:    status_type_q  <= cfg_wdata_i[mcst_pkg::PTYPE_W-1:0];
        mcst_pkg::REG_STATUS5:   status5_type_q <= cfg_wdata_i[mcst_pkg::PTYPE_W-1:0];
        default: ;
      endcase
    end
  end

  // Counters only move on commit, so they hold with the result
  assign result_o.status               = res_status_q;
  assign result_o.online               = res_online_q;
  assign result_o.speed_erpm           = res_speed_q;
  assign result_o.tachometer_count     = res_tach_q;
  assign result_o.rx_error_count       = rx_cnt_q;
  assign result_o.unknown_packet_count = pkt_cnt_q;
  assign result_o.unknown_sender_count = snd_cnt_q;

  a_tick_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.execute && (item_q.command == mcst_pkg::CMD_TICK) |=>
      (now_q == $past(now_q) + 32'd1))
    else $error("tick did not advance the time base");

  a_counters_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.execute |=> $stable(rx_cnt_q) && $stable(pkt_cnt_q) && $stable(snd_cnt_q))
    else $error("error counter moved without a commit");

endmodule

`default_nettype wire

// ===== sv/motor_can_status_telemetry.sv =====
// Channel   Dir  Payload                  Handshake
// in_i      in   mcst_pkg::in_item_t      valid/ready, taken when both high
// out_o     out  mcst_pkg::out_item_t     valid/ready, taken when both high
// cfg       in   index 2b, data 32b       cfg_we_i, written on the edge
//
// Each word is captured first, then decoded and committed to the per-wheel records
// and the result register; no new word is taken until the last one has committed.
// A new word is taken while the previous result still waits at out_o; commit
// stalls only while that result register is full and out_o is not ready.
// Reset is asynchronous, active low, and clears flags, counters and the controller.
`default_nettype none

module motor_can_status_telemetry #(
  parameter int WHEELS = 4
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  mcst_stream_if.sink                          in_i,
  mcst_stream_if.source                        out_o,
  input  wire logic                            cfg_we_i,
  input  wire logic [mcst_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [mcst_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);

  mcst_pkg::ctrl_cmd_t cmd;
  mcst_pkg::out_item_t result;
  logic                in_ready, out_valid;

  // Sequence capture and commit
  mcst_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd)
  );

  // Records, decode and result
  mcst_dp #(
    .WHEELS (WHEELS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .item_i      (in_i.data),
    .result_o    (result),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  assign in_i.ready  = in_ready;
  assign out_o.valid = out_valid;
  assign out_o.data  = result;

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  localparam int CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [mcst_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [mcst_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  mcst_stream_if #(.payload_t(mcst_pkg::in_item_t)) word_ch ();
  mcst_stream_if #(.payload_t(mcst_pkg::out_item_t)) result_ch ();

  motor_can_status_telemetry uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_i       (word_ch),
    .out_o      (result_ch),
    .cfg_we_i   (cfg_we),
    .cfg_index_i(cfg_index),
    .cfg_wdata_i(cfg_wdata)
  );

  always #5 clk = ~clk;

  // Words waiting to be offered, and the telemetry results they must produce
  mcst_pkg::in_item_t  pending_words[$];
  mcst_pkg::out_item_t due_results[$];

  int accepted_words = 0;
  int checked = 0;
  int mismatches = 0;
  int settings_used = 0;
  int cycles = 0;
  int gap_left = 0;
  int burst_left = 0;
  int stall_age = 0;
  int stall_mode = 0;
  logic hold_off = 1'b0;

  // Decoder copy: configuration
  logic [31:0] wheel_id_map;
  logic [31:0] fresh_limit;
  logic [20:0] speed_ptype;
  logic [20:0] tach_ptype;

  // Decoder copy: per-wheel records, tick count and error counters
  logic [31:0] erpm_store [mcst_pkg::ID_SLOTS];
  logic [31:0] tach_raw [mcst_pkg::ID_SLOTS];
  logic [63:0] tach_ext [mcst_pkg::ID_SLOTS];
  logic [31:0] speed_stamp [mcst_pkg::ID_SLOTS];
  logic [31:0] tach_stamp [mcst_pkg::ID_SLOTS];
  logic        speed_seen [mcst_pkg::ID_SLOTS];
  logic        tach_seen [mcst_pkg::ID_SLOTS];
  logic [31:0] tick_now;
  logic [31:0] rx_err;
  logic [31:0] unk_pkt;
  logic [31:0] unk_snd;

  // Advance the decoder copy by one word and return the telemetry it reports
  function automatic mcst_pkg::out_item_t decode_word(input mcst_pkg::in_item_t w);
    mcst_pkg::out_item_t r;
    logic [20:0] ptype;
    logic [31:0] delta;
    logic [31:0] speed_age;
    logic [31:0] tach_age;
    logic [1:0]  s;
    logic        on;
    int hit;
    r = '0;
    r.status = mcst_pkg::ST_DONE;
    ptype = w.frame_id[28:8];
    hit = -1;
    case (w.command)
      mcst_pkg::CMD_FRAME: begin
        if (!w.is_extended || w.is_remote) begin
          r.status = mcst_pkg::ST_IGNORED;
        end else if (ptype != speed_ptype && ptype != tach_ptype) begin
          unk_pkt++;
          r.status = mcst_pkg::ST_UNK_PACKET;
        end else begin
          // first matching slot wins
          for (int i = mcst_pkg::ID_SLOTS - 1; i >= 0; i--) begin
            if (wheel_id_map[8*i +: 8] == w.frame_id[7:0]) hit = i;
          end
          if (hit < 0) begin
            unk_snd++;
            r.status = mcst_pkg::ST_UNK_SENDER;
          end else if (ptype == speed_ptype) begin
            if (w.byte_count < mcst_pkg::MIN_LEN_STATUS) begin
              rx_err++;
              r.status = mcst_pkg::ST_SHORT;
            end else begin
              erpm_store[hit] = w.payload_word;
              speed_stamp[hit] = tick_now;
              speed_seen[hit] = 1'b1;
            end
          end else if (w.byte_count < mcst_pkg::MIN_LEN_STATUS5) begin
            rx_err++;
            r.status = mcst_pkg::ST_SHORT;
          end else begin
            // extend the raw count by its signed wrap delta
            if (!tach_seen[hit]) begin
              tach_ext[hit] = {{32{w.payload_word[31]}}, w.payload_word};
            end else begin
              delta = w.payload_word - tach_raw[hit];
              tach_ext[hit] = tach_ext[hit] + {{32{delta[31]}}, delta};
            end
            tach_raw[hit] = w.payload_word;
            tach_stamp[hit] = tick_now;
            tach_seen[hit] = 1'b1;
          end
        end
      end
      mcst_pkg::CMD_TICK: tick_now++;
      mcst_pkg::CMD_QUERY: begin
        s = w.wheel_select;
        speed_age = tick_now - speed_stamp[s];
        tach_age = tick_now - tach_stamp[s];
        on = speed_seen[s] && tach_seen[s] && speed_age <= fresh_limit &&
             tach_age <= fresh_limit;
        r.online = on;
        r.speed_erpm = on ? erpm_store[s] : 32'd0;
        r.tachometer_count = tach_ext[s];
      end
      default: rx_err++;
    endcase
    r.rx_error_count = rx_err;
    r.unknown_packet_count = unk_pkt;
    r.unknown_sender_count = unk_snd;
    return r;
  endfunction

  function automatic mcst_pkg::in_item_t frame_word(input logic ext, input logic rem,
                                                    input logic [20:0] ptype,
                                                    input logic [7:0] sender,
                                                    input logic [3:0] len,
                                                    input logic [31:0] data);
    mcst_pkg::in_item_t w;
    w.command = mcst_pkg::CMD_FRAME;
    w.is_extended = ext;
    w.is_remote = rem;
    w.frame_id = {ptype, sender};
    w.byte_count = len;
    w.payload_word = data;
    w.wheel_select = 2'($urandom());
    return w;
  endfunction

  // Non-frame command with random don't-care frame fields
  function automatic mcst_pkg::in_item_t command_word(input logic [1:0] cmd,
                                                      input logic [1:0] sel);
    mcst_pkg::in_item_t w;
    w.command = cmd;
    w.is_extended = 1'($urandom());
    w.is_remote = 1'($urandom());
    w.frame_id = 29'($urandom());
    w.byte_count = 4'($urandom());
    w.payload_word = $urandom();
    w.wheel_select = sel;
    return w;
  endfunction

  // Mostly well-formed status frames for known wheels, with ticks, queries and noise
  function automatic mcst_pkg::in_item_t random_word();
    mcst_pkg::in_item_t w;
    int unsigned pick;
    int unsigned wheel;
    logic [20:0] ptype;
    w = command_word(2'($urandom()), 2'($urandom()));
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      w.command = mcst_pkg::CMD_TICK;
    end else if (pick < 33) begin
      w.command = mcst_pkg::CMD_QUERY;
    end else if (pick < 37) begin
      w.command = mcst_pkg::CMD_BUSERR;
    end else begin
      w.command = mcst_pkg::CMD_FRAME;
      if (pick >= 46) begin
        wheel = $urandom_range(0, mcst_pkg::ID_SLOTS - 1);
        ptype = $urandom_range(0, 1) ? speed_ptype : tach_ptype;
        if ($urandom_range(0, 11) == 0) ptype = 21'($urandom());
        w.is_extended = 1'b1;
        w.is_remote = ($urandom_range(0, 19) == 0);
        w.frame_id = {ptype, wheel_id_map[8*wheel +: 8]};
        if ($urandom_range(0, 11) == 0) w.frame_id[7:0] = 8'($urandom());
        w.byte_count = ($urandom_range(0, 6) == 0) ? 4'($urandom()) :
                       4'($urandom_range(6, 8));
        // push the raw count across its wrap now and then
        case ($urandom_range(0, 3))
          0: w.payload_word = {16'h0000, 16'($urandom())};
          1: w.payload_word = {16'hFFFF, 16'($urandom())};
          2: w.payload_word = {16'h8000, 16'($urandom())} - 32'h0000_8000;
          default: ;
        endcase
      end
    end
    return w;
  endfunction

  // Write one register while the block is idle and mirror it in the decoder copy
  task automatic write_reg(input logic [mcst_pkg::CFG_IDX_W-1:0] idx,
                           input logic [31:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      mcst_pkg::REG_WHEEL_IDS: wheel_id_map = value;
      mcst_pkg::REG_TIMEOUT:   fresh_limit = value;
      mcst_pkg::REG_STATUS:    speed_ptype = value[20:0];
      default:                 tach_ptype = value[20:0];
    endcase
  endtask

  // Hold until every word is taken and every result has arrived
  task automatic drain_words();
    while (pending_words.size() != 0 || due_results.size() != 0 || word_ch.valid)
      @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic run_phase(input logic [31:0] ids, input logic [31:0] tmo,
                           input logic [20:0] sp, input logic [20:0] tp, input int n);
    write_reg(mcst_pkg::REG_WHEEL_IDS, ids);
    write_reg(mcst_pkg::REG_TIMEOUT, tmo);
    write_reg(mcst_pkg::REG_STATUS, {11'($urandom()), sp});
    write_reg(mcst_pkg::REG_STATUS5, {11'($urandom()), tp});
    settings_used++;
    repeat (n) pending_words.push_back(random_word());
    drain_words();
  endtask

  // Offer words in bursts with random gaps; keep a word steady until taken
  always @(posedge clk) begin : drive_words
    bit took;
    bit hold;
    bit offer;
    took = word_ch.valid && word_ch.ready;
    hold = word_ch.valid && !took;
    offer = hold;
    if (took) begin
      due_results.push_back(decode_word(word_ch.data));
      void'(pending_words.pop_front());
      accepted_words++;
    end
    if (!rst_n) begin
      offer = 1'b0;
    end else if (!hold) begin
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending_words.size() > 0) begin
        offer = 1'b1;
        if (burst_left == 0)
          burst_left = ($urandom_range(0, 4) == 0) ? 150 : $urandom_range(1, 16);
        burst_left--;
        if (burst_left == 0)
          gap_left = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
      end
    end
    word_ch.valid <= offer;
    if (offer && !hold) word_ch.data <= pending_words[0];
  end

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %h, got %h", name, want, got);
      mismatches++;
    end
  endtask

  // Compare each result word with the oldest expectation; stall on a shifting pattern
  always @(posedge clk) begin : take_results
    mcst_pkg::out_item_t want;
    bit go;
    if (result_ch.valid && result_ch.ready) begin
      if (due_results.size() == 0) begin
        $error("result word with nothing expected, status %0d", result_ch.data.status);
        mismatches++;
      end else begin
        want = due_results.pop_front();
        checked++;
        check_field("status", 64'(want.status), 64'(result_ch.data.status));
        check_field("online", 64'(want.online), 64'(result_ch.data.online));
        check_field("speed_erpm", 64'(want.speed_erpm), 64'(result_ch.data.speed_erpm));
        check_field("tachometer_count", want.tachometer_count,
                    result_ch.data.tachometer_count);
        check_field("rx_error_count", 64'(want.rx_error_count),
                    64'(result_ch.data.rx_error_count));
        check_field("unknown_packet_count", 64'(want.unknown_packet_count),
                    64'(result_ch.data.unknown_packet_count));
        check_field("unknown_sender_count", 64'(want.unknown_sender_count),
                    64'(result_ch.data.unknown_sender_count));
      end
    end
    stall_age++;
    if (stall_age >= 97) begin
      stall_age = 0;
      stall_mode = $urandom_range(0, 3);
    end
    case (stall_mode)
      0: go = 1'b1;
      1: go = ($urandom_range(0, 1) == 1);
      2: go = (stall_age % 4 == 0);
      default: go = ($urandom_range(0, 7) != 0);
    endcase
    result_ch.ready <= rst_n && !hold_off && go;
  end

  // Hold the result side off for a long stretch so the block backs up
  initial begin : long_stall
    while (accepted_words < 400) @(posedge clk);
    hold_off <= 1'b1;
    repeat (300) @(posedge clk);
    hold_off <= 1'b0;
  end

  // Give up on a hung run
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin : run_bench
    word_ch.valid = 1'b0;
    word_ch.data = '0;
    result_ch.ready = 1'b0;
    wheel_id_map = '0;
    fresh_limit = mcst_pkg::TIMEOUT_RST;
    speed_ptype = mcst_pkg::STATUS_RST;
    tach_ptype = mcst_pkg::STATUS5_RST;
    tick_now = '0;
    rx_err = '0;
    unk_pkt = '0;
    unk_snd = '0;
    for (int i = 0; i < mcst_pkg::ID_SLOTS; i++) begin
      erpm_store[i] = '0;
      tach_raw[i] = '0;
      tach_ext[i] = '0;
      speed_stamp[i] = '0;
      tach_stamp[i] = '0;
      speed_seen[i] = 1'b0;
      tach_seen[i] = 1'b0;
    end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed words on the reset settings: every wheel carries sender 0
    settings_used++;
    pending_words.push_back(command_word(mcst_pkg::CMD_QUERY, 2'd0));
    pending_words.push_back(frame_word(1'b0, 1'b0, 21'd9, 8'h00, 4'd8, 32'h1234_5678));
    pending_words.push_back(frame_word(1'b1, 1'b1, 21'd9, 8'h00, 4'd8, 32'h1234_5678));
    pending_words.push_back(frame_word(1'b1, 1'b0, 21'd5, 8'h00, 4'd8, 32'h0));
    pending_words.push_back(frame_word(1'b1, 1'b0, 21'd9, 8'h55, 4'd4, 32'h0));
    pending_words.push_back(frame_word(1'b1, 1'b0, 21'd9, 8'h00, 4'd3, 32'h0));
    pending_words.push_back(frame_word(1'b1, 1'b0, 21'd9, 8'h00, 4'd4, 32'h8000_0000));
    pending_words.push_back(frame_word(1'b1, 1'b0, 21'd27, 8'h00, 4'd5, 32'h0));
    pending_words.push_back(frame_word(1'b1, 1'b0, 21'd27, 8'h00, 4'd6, 32'hFFFF_FFFF));
    pending_words.push_back(frame_word(1'b1, 1'b0, 21'd27, 8'h00, 4'd15, 32'h7FFF_FFFF));
    pending_words.push_back(frame_word(1'b1, 1'b0, 21'd27, 8'h00, 4'd8, 32'h0000_0000));
    pending_words.push_back(command_word(mcst_pkg::CMD_QUERY, 2'd0));
    pending_words.push_back(command_word(mcst_pkg::CMD_QUERY, 2'd3));
    pending_words.push_back(command_word(mcst_pkg::CMD_BUSERR, 2'd0));
    pending_words.push_back(frame_word(1'b1, 1'b0, 21'h1F_FFFF, 8'hFF, 4'd15,
                                       32'hFFFF_FFFF));
    pending_words.push_back(command_word(mcst_pkg::CMD_TICK, 2'd0));
    pending_words.push_back(command_word(mcst_pkg::CMD_QUERY, 2'd0));
    pending_words.push_back(frame_word(1'b1, 1'b0, 21'd9, 8'h00, 4'd4, 32'h7FFF_FFFF));
    pending_words.push_back(command_word(mcst_pkg::CMD_QUERY, 2'd1));
    pending_words.push_back(frame_word(1'b1, 1'b0, 21'd0, 8'h00, 4'd0, 32'h0));
    pending_words.push_back(command_word(mcst_pkg::CMD_QUERY, 2'd0));
    drain_words();

    // Random words over a spread of settings, extremes among them
    run_phase(32'h0403_0201, 32'd100, 21'd9, 21'd27, 250);
    run_phase(32'hFFFF_FFFF, 32'd0, 21'h1F_FFFF, 21'd0, 200);
    run_phase(32'h1122_1122, 32'hFFFF_FFFF, 21'h155, 21'h155, 200);
    run_phase($urandom(), $urandom_range(1, 30), 21'($urandom()), 21'($urandom()), 300);
    run_phase(32'h007F_80FE, 32'd1, 21'd0, 21'h1F_FFFF, 250);
    run_phase($urandom(), 32'd5, 21'd9, 21'd27, 300);
    run_phase(32'h0000_0000, 32'd100, 21'd9, 21'd27, 300);

    $display("Checked %0d telemetry results from %0d words over %0d register settings.",
             checked, accepted_words, settings_used);
    $display("Frames, ticks, queries and bus errors ran with bursty input and stalled output.");
    if (mismatches == 0 && due_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== motor_can_status_telemetry.f =====
sv/mcst_pkg.sv
sv/mcst_stream_if.sv
sv/mcst_ctrl.sv
sv/mcst_dp.sv
sv/motor_can_status_telemetry.sv
bench/testbench.sv
